// ----- hdl/base64_stream_encoder_top_macros.svh -----
`ifndef BASE64_STREAM_ENCODER_TOP_MACROS_SVH
`define BASE64_STREAM_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define B64E_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("b64e assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define B64E_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("b64e assertion failed");

`endif

// ----- hdl/b64e_pkg.sv -----
package b64e_pkg;

    localparam int unsigned MAX_CHARS = 6;
    localparam int unsigned CNT_W     = $clog2(MAX_CHARS + 1);

    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef enum logic [1:0] {
        REG_URL_ALPHABET = 2'd0,
        REG_PAD_ENABLE   = 2'd1,
        REG_CRLF_ENABLE  = 2'd2,
        REG_LINE_QUADS   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic       url_alphabet;
        logic       pad_enable;
        logic       crlf_enable;
        logic [7:0] line_quads;
    } t_cfg;

    // Characters of one request, element 0 goes out first.
    typedef logic [MAX_CHARS-1:0][7:0] t_chars;

    typedef struct packed {
        t_chars           chars;
        logic [CNT_W-1:0] cnt;
    } t_grp;

    function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic url);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return w + 8'd65;
        end else if (v < 6'd52) begin
            return w + 8'd71;
        end else if (v < 6'd62) begin
            return w - 8'd4;
        end else if (v == 6'd62) begin
            return url ? 8'h2D : 8'h2B;
        end else begin
            return url ? 8'h5F : 8'h2F;
        end
    endfunction

endpackage

// ----- hdl/b64e_ifs.sv -----
interface b64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

// ----- hdl/b64e_cfg.sv -----
module b64e_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output b64e_pkg::t_cfg o_cfg
);
    import b64e_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.url_alphabet <= 1'b0;
            r_cfg.pad_enable   <= 1'b1;
            r_cfg.crlf_enable  <= 1'b0;
            r_cfg.line_quads   <= 8'd16;
        end else if (w_wr) begin
            case (w_idx)
                REG_URL_ALPHABET: r_cfg.url_alphabet <= pwdata[0];
                REG_PAD_ENABLE:   r_cfg.pad_enable   <= pwdata[0];
                REG_CRLF_ENABLE:  r_cfg.crlf_enable  <= pwdata[0];
                REG_LINE_QUADS:   r_cfg.line_quads   <= pwdata[7:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_URL_ALPHABET: prdata = {31'd0, r_cfg.url_alphabet};
            REG_PAD_ENABLE:   prdata = {31'd0, r_cfg.pad_enable};
            REG_CRLF_ENABLE:  prdata = {31'd0, r_cfg.crlf_enable};
            REG_LINE_QUADS:   prdata = {24'd0, r_cfg.line_quads};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

// ----- hdl/b64e_enc.sv -----
module b64e_enc (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  b64e_pkg::t_cfg i_cfg,
    b64e_byte_if.sink      i_byte,
    output b64e_pkg::t_grp o_grp,
    output logic           o_grp_valid,
    input  logic           i_grp_ready
);
    import b64e_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic [15:0] r_held;
    logic [1:0]  r_pos;
    logic [7:0]  r_lqc;

    logic [15:0] n_held;
    logic [1:0]  n_pos;
    logic [7:0]  n_lqc;

    logic        w_consume;
    logic [23:0] w_full;
    logic [7:0]  w_lqc_inc;
    logic        w_line_end;
    logic [15:0] w_held_p;
    logic [23:0] w_part;
    logic        w_part_two;
    logic        w_url;
    t_grp        w_grp;

    assign w_url      = i_cfg.url_alphabet;
    assign w_full     = {r_held, r_in_byte};
    assign w_lqc_inc  = r_lqc + 8'd1;
    assign w_line_end = (w_lqc_inc >= i_cfg.line_quads);
    assign w_held_p   = (r_pos == 2'd0) ? {r_in_byte, 8'h00} : {r_held[15:8], r_in_byte};
    assign w_part     = {w_held_p, 8'h00};
    assign w_part_two = (r_pos == 2'd1);

    always_comb begin
        w_grp.chars = '0;
        w_grp.cnt   = '0;
        if (r_pos == 2'd2) begin
            w_grp.chars[0] = sextet_char(w_full[23:18], w_url);
            w_grp.chars[1] = sextet_char(w_full[17:12], w_url);
            w_grp.chars[2] = sextet_char(w_full[11:6], w_url);
            w_grp.chars[3] = sextet_char(w_full[5:0], w_url);
            w_grp.chars[4] = CH_CR;
            w_grp.chars[5] = CH_LF;
            w_grp.cnt      = (w_line_end && i_cfg.crlf_enable) ? CNT_W'(6) : CNT_W'(4);
        end else if (r_in_last) begin
            w_grp.chars[0] = sextet_char(w_part[23:18], w_url);
            w_grp.chars[1] = sextet_char(w_part[17:12], w_url);
            if (w_part_two) begin
                w_grp.chars[2] = sextet_char(w_part[11:6], w_url);
                if (i_cfg.pad_enable) begin
                    w_grp.chars[3] = CH_EQ;
                    w_grp.chars[4] = CH_CR;
                    w_grp.chars[5] = CH_LF;
                    w_grp.cnt      = i_cfg.crlf_enable ? CNT_W'(6) : CNT_W'(4);
                end else begin
                    w_grp.chars[3] = CH_CR;
                    w_grp.chars[4] = CH_LF;
                    w_grp.cnt      = i_cfg.crlf_enable ? CNT_W'(5) : CNT_W'(3);
                end
            end else if (i_cfg.pad_enable) begin
                w_grp.chars[2] = CH_EQ;
                w_grp.chars[3] = CH_EQ;
                w_grp.chars[4] = CH_CR;
                w_grp.chars[5] = CH_LF;
                w_grp.cnt      = i_cfg.crlf_enable ? CNT_W'(6) : CNT_W'(4);
            end else begin
                w_grp.chars[2] = CH_CR;
                w_grp.chars[3] = CH_LF;
                w_grp.cnt      = i_cfg.crlf_enable ? CNT_W'(4) : CNT_W'(2);
            end
        end
    end

    always_comb begin
        n_held = r_held;
        n_pos  = r_pos;
        n_lqc  = r_lqc;
        case (r_pos)
            2'd0: begin
                n_held = {r_in_byte, 8'h00};
                n_pos  = 2'd1;
            end
            2'd1: begin
                n_held = {r_held[15:8], r_in_byte};
                n_pos  = 2'd2;
            end
            default: begin
                n_held = 16'h0000;
                n_pos  = 2'd0;
                n_lqc  = w_line_end ? 8'd0 : w_lqc_inc;
            end
        endcase
        if (r_in_last) begin
            n_held = 16'h0000;
            n_pos  = 2'd0;
            n_lqc  = 8'd0;
        end
    end

    // Requests that emit nothing retire without waiting on the serializer.
    assign w_consume    = r_in_valid && ((w_grp.cnt == '0) || i_grp_ready);
    assign i_byte.ready = !r_in_valid || w_consume;
    assign o_grp        = w_grp;
    assign o_grp_valid  = r_in_valid && (w_grp.cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_held     <= 16'h0000;
            r_pos      <= 2'd0;
            r_lqc      <= 8'd0;
        end else begin
            if (i_byte.ready) begin
                r_in_valid <= i_byte.valid;
            end
            if (w_consume) begin
                r_held <= n_held;
                r_pos  <= n_pos;
                r_lqc  <= n_lqc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
            r_in_last <= i_byte.last_byte;
        end
    end

endmodule

// ----- hdl/b64e_ser.sv -----
module b64e_ser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  b64e_pkg::t_grp i_grp,
    input  logic           i_grp_valid,
    output logic           o_grp_ready,
    b64e_char_if.source    o_char
);
    import b64e_pkg::*;

    t_chars           r_buf;
    logic [CNT_W-1:0] r_cnt;
    logic             w_take;
    logic             w_load;

    assign w_take      = (r_cnt != '0) && o_char.ready;
    assign o_grp_ready = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && w_take);
    assign w_load      = i_grp_valid && o_grp_ready;

    assign o_char.valid     = (r_cnt != '0);
    assign o_char.out_char  = r_buf[0];
    assign o_char.last_char = (r_cnt == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_load) begin
            r_cnt <= i_grp.cnt;
        end else if (w_take) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Advance the character line by one slot per taken character.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_buf <= i_grp.chars;
        end else if (w_take) begin
            r_buf <= {8'h00, r_buf[MAX_CHARS-1:1]};
        end
    end

endmodule

// ----- hdl/base64_stream_encoder_top.sv -----
// Streaming base64 encoder.
// i_byte takes one message byte per request with last_byte on the final one.
// o_char gives the encoded text one character per request; last_char marks
// the final character produced by a given input byte.
// Registers sit on the APB port: url_alphabet at 0x0, pad_enable at 0x4,
// crlf_enable at 0x8, line_quads at 0xC. Write them only while idle.
// Each accepted byte is first held in the input register; its characters
// then load into the character buffer, from which the first one leaves.
// Each byte produces up to six characters; a byte that completes no output
// retires without waiting on the serializer. Throughput: one byte per cycle
// while the output keeps up; the one-character output port sets the long-run
// rate, at most six characters per three bytes.
// A stalled output holds its character; the input keeps taking bytes until
// the input register and the character buffer are both full.
// Reset returns all registers to their defaults and clears the partial group
// and line count; no clearing pass is needed.
`include "base64_stream_encoder_top_macros.svh"

module base64_stream_encoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b64e_byte_if.sink   i_byte,
    b64e_char_if.source o_char,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import b64e_pkg::*;

    t_cfg w_cfg;
    t_grp w_grp;
    logic w_grp_valid;
    logic w_grp_ready;

    b64e_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    b64e_enc u_enc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_byte      (i_byte),
        .o_grp       (w_grp),
        .o_grp_valid (w_grp_valid),
        .i_grp_ready (w_grp_ready)
    );

    b64e_ser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp       (w_grp),
        .i_grp_valid (w_grp_valid),
        .o_grp_ready (w_grp_ready),
        .o_char      (o_char)
    );

    `B64E_ASSERT_SAME(a_grp_cnt, w_grp_valid, (w_grp.cnt >= CNT_W'(2)) && (w_grp.cnt <= CNT_W'(6)))
    `B64E_ASSERT_NEXT(a_load_shows, w_grp_valid && w_grp_ready, o_char.valid)
    `B64E_ASSERT_NEXT(a_drain_idle,
        o_char.valid && o_char.ready && o_char.last_char && !w_grp_valid, !o_char.valid)

endmodule
